@@ design/sib_pkg.sv @@
// ----------------------------------------------------------------------------
// sib_pkg: shared definitions for the sorted insertion buffer
// Capacity, derived widths, command and status codes, and the struct types
// used between the sequencer and the entry store.
// ----------------------------------------------------------------------------
package sib_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 4;

	localparam logic [1:0] CMD_INSERT    = 2'd0;
	localparam logic [1:0] CMD_LIST_ASC  = 2'd1;
	localparam logic [1:0] CMD_LIST_DESC = 2'd2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_ELEMENT  = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [VAL_W-1:0] wr_data;
		logic [IDX_W-1:0] rd_addr;
		logic [VAL_W-1:0] cmp_val;
	} store_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] rd_data;
		logic             gt;
	} store_rsp_t;

endpackage

@@ design/sorted_insert_buffer_unit.sv @@
// Insert: one compare-and-shift per cycle through the single comparator, then
// the status is answered; full and empty commands answer without touching the
// store; a list gives one element per cycle while the output is not stalled.
// A new command is taken only once the previous one has been answered into
// the output register; output stalls hold the list and answer steps.
// Reset (arst_n low): store empty, no result pending; entries are not cleared.
// ----------------------------------------------------------------------------
// sorted_insert_buffer_unit: sorted insertion buffer, top level
// Stream in commands, stream out insert status or the sorted store contents.
// ----------------------------------------------------------------------------
module sorted_insert_buffer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [1:0] command, [5:2] card_value, [7:6] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [1:0] status, [5:2] listed_value, [7:6] zero
	output logic       m_tlast
);

	sib_pkg::store_req_t req;
	sib_pkg::store_rsp_t rsp;
	logic [1:0]          out_status;
	logic [3:0]          out_listed_value;

	sib_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.in_command       (s_tdata[1:0]),
		.in_card_value    (s_tdata[5:2]),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.out_status       (out_status),
		.out_listed_value (out_listed_value),
		.out_last_flag    (m_tlast),
		.req              (req),
		.rsp              (rsp)
	);

	sib_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	assign m_tdata = {2'b00, out_listed_value, out_status};

endmodule

@@ design/sib_store.sv @@
// ----------------------------------------------------------------------------
// sib_store: entry store with shared magnitude comparator
// One write port, one read port; the read entry is compared against the
// value being inserted by the single comparator of the block.
// ----------------------------------------------------------------------------
module sib_store (
	input  logic                 clk,
	input  sib_pkg::store_req_t  req,
	output sib_pkg::store_rsp_t  rsp
);

	logic [sib_pkg::VAL_W-1:0] entry_q [sib_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			entry_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_comb begin
		rsp.rd_data = entry_q[req.rd_addr];
		rsp.gt      = (entry_q[req.rd_addr] > req.cmp_val);
	end

endmodule

@@ design/sib_ctrl.sv @@
// ----------------------------------------------------------------------------
// sib_ctrl: command sequencer and output register
// Steps the insertion shift one slot per cycle, walks the store for list
// commands, and holds each result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sib_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           in_command,
	input  logic [3:0]           in_card_value,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [1:0]           out_status,
	output logic [3:0]           out_listed_value,
	output logic                 out_last_flag,
	output sib_pkg::store_req_t  req,
	input  sib_pkg::store_rsp_t  rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]                state_q;
	logic [sib_pkg::CNT_W-1:0] count_q;
	logic [sib_pkg::IDX_W-1:0] pos_q;
	logic [sib_pkg::IDX_W-1:0] i_q;
	logic [sib_pkg::VAL_W-1:0] val_q;
	logic                      desc_q;
	logic [1:0]                emit_status_q;
	logic                      m_valid_q;
	logic [1:0]                out_status_q;
	logic [3:0]                out_value_q;
	logic                      out_last_q;

	logic                      s_fire;
	logic                      slot_free;
	logic                      out_load;
	logic                      ins_stop;
	logic [sib_pkg::CNT_W-1:0] i_ext;
	logic [sib_pkg::CNT_W-1:0] desc_idx;
	logic [sib_pkg::IDX_W-1:0] list_idx;
	logic                      list_last;

	assign s_tready  = (state_q == S_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign out_load  = slot_free && ((state_q == S_LIST) || (state_q == S_EMIT));
	assign ins_stop  = (pos_q == '0) || !rsp.gt;

	assign i_ext     = sib_pkg::CNT_W'(i_q);
	assign desc_idx  = count_q - sib_pkg::CNT_W'(1) - i_ext;
	assign list_idx  = desc_q ? desc_idx[sib_pkg::IDX_W-1:0] : i_q;
	assign list_last = ((i_ext + sib_pkg::CNT_W'(1)) == count_q);

	always_comb begin
		req.rd_addr = (state_q == S_LIST) ? list_idx : (pos_q - sib_pkg::IDX_W'(1));
		req.wr_en   = (state_q == S_INS);
		req.wr_addr = pos_q;
		req.wr_data = ins_stop ? val_q : rsp.rd_data;
		req.cmp_val = val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			m_valid_q     <= 1'b0;
			pos_q         <= '0;
			i_q           <= '0;
			val_q         <= '0;
			desc_q        <= 1'b0;
			emit_status_q <= sib_pkg::ST_INSERTED;
			out_status_q  <= sib_pkg::ST_INSERTED;
			out_value_q   <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						val_q <= in_card_value;
						unique case (in_command)
							sib_pkg::CMD_INSERT: begin
								if (count_q == sib_pkg::CNT_W'(sib_pkg::CAPACITY)) begin
									emit_status_q <= sib_pkg::ST_FULL;
									state_q       <= S_EMIT;
								end else begin
									pos_q   <= count_q[sib_pkg::IDX_W-1:0];
									state_q <= S_INS;
								end
							end
							sib_pkg::CMD_LIST_ASC, sib_pkg::CMD_LIST_DESC: begin
								if (count_q == '0) begin
									emit_status_q <= sib_pkg::ST_EMPTY;
									state_q       <= S_EMIT;
								end else begin
									i_q     <= '0;
									desc_q  <= (in_command == sib_pkg::CMD_LIST_DESC);
									state_q <= S_LIST;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INS: begin
					if (ins_stop) begin
						count_q       <= count_q + sib_pkg::CNT_W'(1);
						emit_status_q <= sib_pkg::ST_INSERTED;
						state_q       <= S_EMIT;
					end else begin
						pos_q <= pos_q - sib_pkg::IDX_W'(1);
					end
				end
				S_LIST: begin
					if (slot_free) begin
						out_status_q <= sib_pkg::ST_ELEMENT;
						out_value_q  <= rsp.rd_data;
						out_last_q   <= list_last;
						i_q          <= i_q + sib_pkg::IDX_W'(1);
						if (list_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_status_q <= emit_status_q;
						out_value_q  <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid         = m_valid_q;
	assign out_status       = out_status_q;
	assign out_listed_value = out_value_q;
	assign out_last_flag    = out_last_q;

endmodule

@@ tb/sv/tb_sorted_insert_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_insert_buffer_unit: self-checking bench for the sorted buffer
// Drives insert, list and unused commands through the input stream. A
// behavioral copy of the sorted store predicts results unless a table row
// types its own; each result transaction is checked in order, field by field,
// against that expectation. A directed table comes first: empty lists, edge and
// equal values, filling to capacity, and rejects when full. Random commands
// follow, with random idle bursts on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_insert_buffer_unit;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_FROM   = 240;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [1:0]                status;
		logic [sib_pkg::VAL_W-1:0] value;
		logic                      last;
	} card_result_t;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [sib_pkg::VAL_W-1:0] val;
		logic                      typed;
		card_result_t              exp;
	} card_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	logic [sib_pkg::VAL_W-1:0] card_store [sib_pkg::CAPACITY];
	int                        card_count;
	card_result_t              pending_results [$];

	logic         row_typed;
	card_result_t row_exp;
	bit           random_phase;
	bit           quiet;
	int           errors;
	int           cycles;
	int           items_in;
	int           results_out;
	int           rejects_seen;
	int           elements_seen;

	sorted_insert_buffer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// updates the store copy; record=0 leaves the results to a typed-in row
	task automatic apply_card_command(input logic [1:0] cmd,
			input logic [sib_pkg::VAL_W-1:0] val, input bit record);
		int pos;
		int idx;
		case (cmd)
			sib_pkg::CMD_INSERT: begin
				if (card_count >= sib_pkg::CAPACITY) begin
					if (record)
						pending_results.push_back({sib_pkg::ST_FULL, 4'd0, 1'b1});
				end else begin
					pos = card_count;
					while (pos > 0 && card_store[pos-1] > val) begin
						card_store[pos] = card_store[pos-1];
						pos--;
					end
					card_store[pos] = val;
					card_count++;
					if (record)
						pending_results.push_back({sib_pkg::ST_INSERTED, 4'd0, 1'b1});
				end
			end
			sib_pkg::CMD_LIST_ASC, sib_pkg::CMD_LIST_DESC: begin
				if (card_count == 0) begin
					if (record)
						pending_results.push_back({sib_pkg::ST_EMPTY, 4'd0, 1'b1});
				end else if (record) begin
					for (int i = 0; i < card_count; i++) begin
						idx = (cmd == sib_pkg::CMD_LIST_ASC) ? i : card_count - 1 - i;
						pending_results.push_back({sib_pkg::ST_ELEMENT, card_store[idx],
							logic'(i + 1 == card_count)});
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] cmd, input logic [sib_pkg::VAL_W-1:0] val,
			input logic typed, input card_result_t exp, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid  <= 1'b1;
		s_tdata   <= {2'b00, val, cmd};
		row_typed <= typed;
		row_exp   <= exp;
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		card_result_t want;
		card_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[1:0], m_tdata[5:2], m_tlast};
				results_out++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d value=%0d last=%0d",
						$time, got.status, got.value, got.last);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (want.status == sib_pkg::ST_FULL)
						rejects_seen++;
					if (want.status == sib_pkg::ST_ELEMENT)
						elements_seen++;
					if (got.status !== want.status)
						$display("%0t: status mismatch expected %0d actual %0d",
							$time, want.status, got.status);
					if (got.value !== want.value)
						$display("%0t: listed_value mismatch expected %0d actual %0d",
							$time, want.value, got.value);
					if (got.last !== want.last)
						$display("%0t: tlast mismatch expected %0d actual %0d",
							$time, want.last, got.last);
					if (got !== want)
						errors++;
				end
			end
			if (s_tvalid && s_tready) begin
				items_in++;
				if (row_typed) begin
					apply_card_command(s_tdata[1:0], s_tdata[5:2], 1'b0);
					pending_results.push_back(row_exp);
				end else begin
					apply_card_command(s_tdata[1:0], s_tdata[5:2], 1'b1);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("tb_sorted_insert_buffer_unit failed");
			$finish;
		end
	end

	// output side: random stall bursts plus one long hold-off
	initial begin
		int  hold;
		bit  long_done;
		hold      = 0;
		long_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (random_phase && !long_done) begin
				long_done = 1'b1;
				hold      = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!quiet && arst_n && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	initial begin
		card_row_t dir_rows [$];
		int        gap;
		logic [1:0] cmd;
		s_tvalid     = 1'b0;
		s_tdata      = 8'd0;
		row_typed    = 1'b0;
		row_exp      = '0;
		arst_n       = 1'b0;
		random_phase = 1'b0;
		quiet        = 1'b0;
		errors       = 0;
		cycles       = 0;
		items_in     = 0;
		results_out  = 0;
		rejects_seen = 0;
		elements_seen = 0;
		card_count   = 0;

		dir_rows = '{
			{sib_pkg::CMD_LIST_ASC,  4'd0,  1'b1, sib_pkg::ST_EMPTY,    4'd0, 1'b1},
			{sib_pkg::CMD_LIST_DESC, 4'd9,  1'b1, sib_pkg::ST_EMPTY,    4'd0, 1'b1},
			{CMD_UNUSED,             4'd15, 1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd13, 1'b1, sib_pkg::ST_INSERTED, 4'd0, 1'b1},
			{sib_pkg::CMD_LIST_ASC,  4'd15, 1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd1,  1'b1, sib_pkg::ST_INSERTED, 4'd0, 1'b1},
			{sib_pkg::CMD_INSERT,    4'd0,  1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd15, 1'b0, 7'd0},
			{sib_pkg::CMD_LIST_DESC, 4'd6,  1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd14, 1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd7,  1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd7,  1'b0, 7'd0},
			{sib_pkg::CMD_LIST_ASC,  4'd10, 1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd1,  1'b0, 7'd0},
			{sib_pkg::CMD_INSERT,    4'd5,  1'b1, sib_pkg::ST_FULL,     4'd0, 1'b1},
			{sib_pkg::CMD_INSERT,    4'd0,  1'b1, sib_pkg::ST_FULL,     4'd0, 1'b1},
			{sib_pkg::CMD_INSERT,    4'd15, 1'b1, sib_pkg::ST_FULL,     4'd0, 1'b1},
			{sib_pkg::CMD_LIST_ASC,  4'd3,  1'b0, 7'd0},
			{sib_pkg::CMD_LIST_DESC, 4'd12, 1'b0, 7'd0},
			{CMD_UNUSED,             4'd0,  1'b0, 7'd0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed,
				dir_rows[i].exp, (i % 4 == 3) ? $urandom_range(1, 12) : 0);

		random_phase = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= QUIET_FROM)
				quiet = 1'b1;
			gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			cmd = ($urandom_range(0, 9) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
			send_item(cmd, 4'($urandom_range(0, 15)), 1'b0, '0, gap);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands in, %0d results out: %0d list elements, %0d full rejects",
			items_in, results_out, elements_seen, rejects_seen);
		$display("stalls on both sides, one %0d-cycle output hold-off, %0d errors",
			LONG_HOLD, errors);
		if (errors == 0)
			$display("tb_sorted_insert_buffer_unit passed");
		else
			$display("tb_sorted_insert_buffer_unit failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/sib_pkg.sv
design/sib_store.sv
design/sib_ctrl.sv
design/sorted_insert_buffer_unit.sv
tb/sv/tb_sorted_insert_buffer_unit.sv
